/* rtl/core/mcc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and level scaling for the 14-bit controller pairing mapper.
// No dependencies; every other file in rtl/core imports this package.
package mcc_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int LEVEL_BITS    = 15;
	localparam int NUM_BITS      = 7;
	localparam int RAW_BITS      = 7;
	localparam int WINDOW_BITS   = 16;

	localparam logic [WINDOW_BITS-1:0] PAIR_WINDOW_RST = 16'd500;
	localparam logic [NUM_BITS-1:0]    KNOB_A_RST      = 7'd21;
	localparam logic [NUM_BITS-1:0]    KNOB_B_RST      = 7'd22;
	localparam logic [NUM_BITS-1:0]    PARTNER_OFFSET  = 7'd32;
	localparam logic [LEVEL_BITS:0]    FULL_SCALE      = 16'd32767;

	typedef enum logic [2:0] {
		OP_CC       = 3'd0,
		OP_NOTE_ON  = 3'd1,
		OP_NOTE_OFF = 3'd2,
		OP_ARM_A    = 3'd3,
		OP_ARM_B    = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		LEARN_NONE = 2'd0,
		LEARN_A    = 2'd1,
		LEARN_B    = 2'd2
	} learn_t;

	typedef enum logic {
		KIND_CTRL = 1'b0,
		KIND_NOTE = 1'b1
	} kind_t;

	typedef struct packed {
		logic [2:0]          opcode;
		logic [NUM_BITS-1:0] number;
		logic [RAW_BITS-1:0] raw_value;
		logic [31:0]         timestamp_ms;
	} in_item_t;

	typedef struct packed {
		logic                   event_kind;
		logic [NUM_BITS-1:0]    target_number;
		logic [LEVEL_BITS-1:0]  level;
		logic                   fine_paired;
		logic                   knob_a_update;
		logic signed [LEVEL_BITS:0] knob_a_level;
		logic                   knob_b_update;
		logic [LEVEL_BITS-1:0]  knob_b_level;
	} out_item_t;

	// Full scale 32767 is 258 * 127 + 1, so v * 32767 / 127 rounded is
	// 258 * v plus one for the upper half of the input range.
	function automatic logic [LEVEL_BITS-1:0] scale7(input logic [RAW_BITS-1:0] v);
		logic [LEVEL_BITS-1:0] base;
		begin
			base = LEVEL_BITS'(v) * LEVEL_BITS'(258);
			scale7 = base + LEVEL_BITS'(v[RAW_BITS-1]);
		end
	endfunction

	// Full scale 32767 is 2 * 16383 + 1, so v * 32767 / 16383 rounded is
	// 2 * v plus one once v reaches 8192.
	function automatic logic [LEVEL_BITS-1:0] scale14(input logic [13:0] v);
		scale14 = {v, 1'b0} + LEVEL_BITS'(v[13]);
	endfunction

endpackage

/* rtl/core/mcc_coarse_store.sv */
`timescale 1ns / 1ps
// Coarse value and time store: one write port, one registered read port.
// A read of the entry being written in the same cycle returns the new data.
// Depends on mcc_pkg.
module mcc_coarse_store #(
	parameter int TIME_BITS = mcc_pkg::TIME_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   rd_en,
	input  logic [mcc_pkg::NUM_BITS-1:0]           rd_addr,
	input  logic                                   wr_en,
	input  logic [mcc_pkg::NUM_BITS-1:0]           wr_addr,
	input  logic [mcc_pkg::RAW_BITS+TIME_BITS-1:0] wr_data,
	output logic [mcc_pkg::RAW_BITS+TIME_BITS-1:0] rd_data
);
	import mcc_pkg::*;

	localparam int ENTRY_BITS = RAW_BITS + TIME_BITS;
	localparam int DEPTH      = 1 << NUM_BITS;

	logic [ENTRY_BITS-1:0] mem [DEPTH];
	logic [ENTRY_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

/* rtl/core/midi_cc_14bit_pairing_mapper.sv */
`timescale 1ns / 1ps
// Top level of the 14-bit controller pairing mapper with knob learn.
// Depends on mcc_pkg and mcc_coarse_store.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     mcc_pkg::in_item_t
// out       output     out_valid / out_stall   mcc_pkg::out_item_t
// cfg       input      cfg_we                  cfg_wdata, pair window in ms
//
// An item reads its partner entry from the store in the cycle it is accepted and
// is resolved, written back and registered for output once the output can advance;
// items may follow one per cycle while the output is not stalled. Reset clears
// the seen flags and learn state and presets the knob numbers and window at once;
// the store itself needs no clearing. A stalled output holds the stage behind it.
module midi_cc_14bit_pairing_mapper #(
	parameter int TIME_BITS = mcc_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  mcc_pkg::in_item_t                  in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output mcc_pkg::out_item_t                 out_item,
	input  logic                               cfg_we,
	input  logic [mcc_pkg::WINDOW_BITS-1:0]    cfg_wdata
);
	import mcc_pkg::*;

	localparam int ENTRY_BITS = RAW_BITS + TIME_BITS;

	logic [WINDOW_BITS-1:0] pair_window_q;
	logic [(1<<NUM_BITS)-1:0] seen_q;
	learn_t                 learn_q;
	logic [NUM_BITS-1:0]    knob_a_q;
	logic [NUM_BITS-1:0]    knob_b_q;

	logic                   valid_s1;
	in_item_t               item_s1;
	logic                   out_valid_q;
	out_item_t              out_item_q;

	logic                   advance;
	logic                   fire;
	logic                   accept;
	logic                   wr_en;
	logic [ENTRY_BITS-1:0]  rd_data;
	logic [ENTRY_BITS-1:0]  wr_data;

	logic [63:0]            ts_ext;
	logic [TIME_BITS-1:0]   now_s1;
	logic [TIME_BITS-1:0]   ctime_s1;
	logic [RAW_BITS-1:0]    cvalue_s1;
	logic [TIME_BITS-1:0]   dt_s1;
	logic [NUM_BITS-1:0]    partner_s1;
	logic                   paired_s1;
	logic                   has_res_s1;
	logic [LEVEL_BITS-1:0]  lvl7_s1;
	logic [LEVEL_BITS-1:0]  lvl14_s1;
	logic [NUM_BITS-1:0]    knob_a_eff;
	logic [NUM_BITS-1:0]    knob_b_eff;
	out_item_t              res_s1;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign ts_ext     = 64'(item_s1.timestamp_ms);
	assign now_s1     = ts_ext[TIME_BITS-1:0];
	assign ctime_s1   = rd_data[TIME_BITS-1:0];
	assign cvalue_s1  = rd_data[ENTRY_BITS-1:TIME_BITS];
	assign dt_s1      = now_s1 - ctime_s1;
	assign partner_s1 = item_s1.number - PARTNER_OFFSET;
	assign paired_s1  = (item_s1.opcode == OP_CC)
		&& (item_s1.number[NUM_BITS-1] || item_s1.number[NUM_BITS-2])
		&& seen_q[partner_s1]
		&& (dt_s1 < TIME_BITS'(pair_window_q));
	assign lvl7_s1    = scale7(item_s1.raw_value);
	assign lvl14_s1   = scale14({cvalue_s1, item_s1.raw_value});
	assign knob_a_eff = (learn_q == LEARN_A) ? item_s1.number : knob_a_q;
	assign knob_b_eff = (learn_q == LEARN_B) ? item_s1.number : knob_b_q;
	assign wr_en      = fire && (item_s1.opcode == OP_CC) && !paired_s1;
	assign wr_data    = {item_s1.raw_value, now_s1};

	mcc_coarse_store #(
		.TIME_BITS(TIME_BITS)
	) u_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_item.number - PARTNER_OFFSET),
		.wr_en   (wr_en),
		.wr_addr (item_s1.number),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	always_comb begin
		res_s1 = '0;
		has_res_s1 = 1'b0;
		case (item_s1.opcode)
			OP_NOTE_ON: begin
				has_res_s1 = 1'b1;
				res_s1.event_kind = KIND_NOTE;
				res_s1.target_number = item_s1.number;
				res_s1.level = lvl7_s1;
			end
			OP_NOTE_OFF: begin
				has_res_s1 = 1'b1;
				res_s1.event_kind = KIND_NOTE;
				res_s1.target_number = item_s1.number;
			end
			OP_CC: begin
				has_res_s1 = 1'b1;
				res_s1.event_kind = KIND_CTRL;
				if (paired_s1) begin
					res_s1.target_number = partner_s1;
					res_s1.level = lvl14_s1;
					res_s1.fine_paired = 1'b1;
				end else begin
					res_s1.target_number = item_s1.number;
					res_s1.level = lvl7_s1;
					if (item_s1.number == knob_a_eff) begin
						res_s1.knob_a_update = 1'b1;
						res_s1.knob_a_level = {lvl7_s1, 1'b0} - FULL_SCALE;
					end else if (item_s1.number == knob_b_eff) begin
						res_s1.knob_b_update = 1'b1;
						res_s1.knob_b_level = lvl7_s1;
					end
				end
			end
			default: begin
				has_res_s1 = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_window_q <= PAIR_WINDOW_RST;
		end else if (cfg_we) begin
			pair_window_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			learn_q  <= LEARN_NONE;
			knob_a_q <= KNOB_A_RST;
			knob_b_q <= KNOB_B_RST;
		end else if (fire) begin
			case (item_s1.opcode)
				OP_ARM_A: begin
					learn_q <= LEARN_A;
				end
				OP_ARM_B: begin
					learn_q <= LEARN_B;
				end
				OP_CC: begin
					if (!paired_s1) begin
						seen_q[item_s1.number] <= 1'b1;
						knob_a_q <= knob_a_eff;
						knob_b_q <= knob_b_eff;
						learn_q  <= LEARN_NONE;
					end
				end
				default: begin
					learn_q <= learn_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && has_res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= res_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
